>>> rtl/tfa_pkg.sv
// Shared types and constants for the TLB / FIFO-replacement address translator.
// Used by tfa_tlb_cell, tfa_frame_cell and tlb_fifo_address_translator; no dependencies.
package tfa_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned PHYS_W      = 14;
  localparam int unsigned FRAME_OUT_W = 6;

  // Default geometry
  localparam int unsigned TLB_DEPTH_DEF   = 128;
  localparam int unsigned FRAME_COUNT_DEF = 64;
  localparam int unsigned OFFSET_BITS_DEF = 8;

  // Control handed from the sequencer to every cell of a chain
  typedef struct packed {
    logic cmp_en;  // register the compare against the broadcast page
    logic ins_en;  // write the token holder and pass the token on
  } cell_ctrl_t;

endpackage

>>> rtl/tfa_tlb_cell.sv
// One TLB entry cell: valid bit, page tag, frame, and a slot of the insertion token ring.
// Depends on tfa_pkg.
module tfa_tlb_cell #(
  parameter int unsigned PAGE_W     = 8,
  parameter int unsigned FRAME_W    = 6,
  parameter bit          FIRST_CELL = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfa_pkg::cell_ctrl_t ctrl_i,
  input  logic [PAGE_W-1:0]   page_i,
  input  logic [FRAME_W-1:0]  frame_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                match_o,
  output logic [FRAME_W-1:0]  frame_o
);

  logic               valid_q, valid_d;
  logic               tok_q, tok_d;
  logic               match_q, match_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               wr_en;

  assign wr_en = ctrl_i.ins_en & tok_q;

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    frame_d = frame_q;
    tok_d   = tok_q;
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q & (page_q == page_i);
    end
    if (wr_en) begin
      valid_d = 1'b1;
      page_d  = page_i;
      frame_d = frame_i;
    end
    // advance the token one cell along the ring
    if (ctrl_i.ins_en) begin
      tok_d = tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= FIRST_CELL;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    frame_q <= frame_d;
  end

  assign tok_o   = tok_q;
  assign match_o = match_q;
  assign frame_o = frame_q;

endmodule

>>> rtl/tfa_frame_cell.sv
// One inverted page table cell: owner valid bit, owning page, and a slot of the
// round-robin frame token ring. Depends on tfa_pkg.
module tfa_frame_cell #(
  parameter int unsigned PAGE_W     = 8,
  parameter bit          FIRST_CELL = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfa_pkg::cell_ctrl_t ctrl_i,
  input  logic [PAGE_W-1:0]   page_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                match_o
);

  logic              valid_q, valid_d;
  logic              tok_q, tok_d;
  logic              match_q, match_d;
  logic [PAGE_W-1:0] page_q, page_d;

  always_comb begin
    valid_d = valid_q;
    page_d  = page_q;
    tok_d   = tok_q;
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q & (page_q == page_i);
    end
    // claim this frame for the page and hand the token on
    if (ctrl_i.ins_en) begin
      tok_d = tok_i;
      if (tok_q) begin
        valid_d = 1'b1;
        page_d  = page_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= FIRST_CELL;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign tok_o   = tok_q;
  assign match_o = match_q;

endmodule

>>> rtl/tlb_fifo_address_translator.sv
// Top level: TLB with FIFO page replacement, built from two rows of cells and a sequencer.
// Depends on tfa_pkg, tfa_tlb_cell and tfa_frame_cell.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------------
//   request | in        | in_valid_i / in_stall_o    | logical_addr_i[15:0]
//   result  | out       | out_valid_o / out_stall_i  | phys_addr_o, tlb_hit_o, page_fault_o,
//           |           |                            | frame_used_o
//
// Each request goes through these steps in order: accept and register the address, compare
// the page in every TLB cell and every frame cell at once (match bits registered in the
// cells), then pick the lowest matching cell, write back the insertion and load the result
// register. The next request is accepted the cycle after the write-back, so the block takes
// one request at a time; a new one can enter while the previous result waits in the output register.
// Reset clears all valid bits and sets both insertion tokens to cell 0; no clearing pass.
// A stalled result holds the write-back step until the output register is free.
module tlb_fifo_address_translator #(
  parameter int unsigned TLB_DEPTH   = tfa_pkg::TLB_DEPTH_DEF,
  parameter int unsigned FRAME_COUNT = tfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tfa_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tfa_pkg::ADDR_W-1:0]      logical_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tfa_pkg::PHYS_W-1:0]      phys_addr_o,
  output logic                            tlb_hit_o,
  output logic                            page_fault_o,
  output logic [tfa_pkg::FRAME_OUT_W-1:0] frame_used_o
);

  // Page field is the address above the offset; keep at least one bit so that a
  // full-width offset still elaborates (the page is then always zero).
  localparam int unsigned RAW_PAGE_W = tfa_pkg::ADDR_W - OFFSET_BITS;
  localparam int unsigned PAGE_W     = (RAW_PAGE_W > 0) ? RAW_PAGE_W : 1;
  localparam int unsigned FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned PF_W       = FRAME_W + OFFSET_BITS;

  // Sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_LOOKUP  = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [PAGE_W-1:0]      page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [tfa_pkg::ADDR_W-1:0] addr_shift;

  logic                   in_accept;
  logic                   resolve_go;

  tfa_pkg::cell_ctrl_t    tlb_ctrl, frm_ctrl;

  // Cell row signals
  logic [TLB_DEPTH-1:0]   tlb_tok;
  logic [TLB_DEPTH-1:0]   tlb_match;
  logic [TLB_DEPTH-1:0]   tlb_first;
  logic [FRAME_W-1:0]     tlb_frame [TLB_DEPTH];
  logic [FRAME_COUNT-1:0] frm_tok;
  logic [FRAME_COUNT-1:0] frm_match;
  logic [FRAME_COUNT-1:0] frm_first;

  logic                   hit, own_hit;
  logic [FRAME_W-1:0]     hit_frame, own_frame, new_frame, res_frame;

  logic [PF_W+tfa_pkg::PHYS_W-1:0]      phys_wide;
  logic [FRAME_W+tfa_pkg::FRAME_OUT_W-1:0] frame_wide;

  logic                            out_valid_q, out_valid_d;
  logic [tfa_pkg::PHYS_W-1:0]      phys_q;
  logic                            hit_q, fault_q;
  logic [tfa_pkg::FRAME_OUT_W-1:0] frame_out_q;

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign addr_shift = logical_addr_i >> OFFSET_BITS;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      page_q   <= addr_shift[PAGE_W-1:0];
      offset_q <= logical_addr_i[OFFSET_BITS-1:0];
    end
  end

  // Write-back may proceed only when the output register is free or drains now
  assign resolve_go = (state_q == ST_RESOLVE) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_accept) state_d = ST_LOOKUP;
      ST_LOOKUP:  state_d = ST_RESOLVE;
      ST_RESOLVE: if (resolve_go) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Cell rows: compare in LOOKUP, insert in RESOLVE
  // ---------------------------------------------------------------------------
  assign tlb_ctrl.cmp_en = (state_q == ST_LOOKUP);
  assign tlb_ctrl.ins_en = resolve_go & ~hit;
  assign frm_ctrl.cmp_en = (state_q == ST_LOOKUP);
  assign frm_ctrl.ins_en = resolve_go & ~hit & ~own_hit;

  for (genvar gi = 0; gi < TLB_DEPTH; gi++) begin : g_tlb
    tfa_tlb_cell #(
      .PAGE_W    (PAGE_W),
      .FRAME_W   (FRAME_W),
      .FIRST_CELL(gi == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (tlb_ctrl),
      .page_i (page_q),
      .frame_i(res_frame),
      .tok_i  (tlb_tok[(gi + TLB_DEPTH - 1) % TLB_DEPTH]),
      .tok_o  (tlb_tok[gi]),
      .match_o(tlb_match[gi]),
      .frame_o(tlb_frame[gi])
    );
  end

  for (genvar gf = 0; gf < FRAME_COUNT; gf++) begin : g_frm
    tfa_frame_cell #(
      .PAGE_W    (PAGE_W),
      .FIRST_CELL(gf == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (frm_ctrl),
      .page_i (page_q),
      .tok_i  (frm_tok[(gf + FRAME_COUNT - 1) % FRAME_COUNT]),
      .tok_o  (frm_tok[gf]),
      .match_o(frm_match[gf])
    );
  end

  // ---------------------------------------------------------------------------
  // Lowest-index match: isolate the lowest set bit, then gather by one-hot OR
  // ---------------------------------------------------------------------------
  assign tlb_first = tlb_match & (~tlb_match + TLB_DEPTH'(1));
  assign frm_first = frm_match & (~frm_match + FRAME_COUNT'(1));
  assign hit       = |tlb_match;
  assign own_hit   = |frm_match;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      hit_frame = hit_frame | ({FRAME_W{tlb_first[i]}} & tlb_frame[i]);
    end
  end

  always_comb begin
    own_frame = '0;
    new_frame = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      own_frame = own_frame | ({FRAME_W{frm_first[i]}} & FRAME_W'(i));
      new_frame = new_frame | ({FRAME_W{frm_tok[i]}} & FRAME_W'(i));
    end
  end

  // Hit: frame from the TLB (may be stale after reuse). Miss: owner, else new frame.
  always_comb begin
    priority if (hit) begin
      res_frame = hit_frame;
    end else if (own_hit) begin
      res_frame = own_frame;
    end else begin
      res_frame = new_frame;
    end
  end

  assign phys_wide  = {{tfa_pkg::PHYS_W{1'b0}}, res_frame, offset_q};
  assign frame_wide = {{tfa_pkg::FRAME_OUT_W{1'b0}}, res_frame};

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (resolve_go) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve_go) begin
      phys_q      <= phys_wide[tfa_pkg::PHYS_W-1:0];
      hit_q       <= hit;
      fault_q     <= ~hit & ~own_hit;
      frame_out_q <= frame_wide[tfa_pkg::FRAME_OUT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign phys_addr_o  = phys_q;
  assign tlb_hit_o    = hit_q;
  assign page_fault_o = fault_q;
  assign frame_used_o = frame_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tlb_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tlb_tok))
    else $error("TLB insertion token lost or duplicated");

  a_frm_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(frm_tok))
    else $error("frame replacement token lost or duplicated");

  a_fault_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(fault_q && hit_q))
    else $error("result flags both a TLB hit and a page fault");

  a_result_after_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESOLVE))
    else $error("result appeared without a write-back step");

  a_frame_tok_moves_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_ctrl.ins_en |=> (frm_tok != $past(frm_tok)) || (FRAME_COUNT == 1))
    else $error("frame token did not advance on a page fault");

endmodule
